[sv/linear_interp_resampler_defines.svh]
// assertion macros for the linear interpolation resampler checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lir_pkg.sv]
// shared constants and helpers for the linear interpolation resampler
// no dependencies
package lir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int FRAC_W       = 32;
    localparam int STEP_W       = 40;
    localparam int CHAN_W       = 2;
    localparam int DIGIT_W      = 4;
    localparam int N_DIGITS     = FRAC_W / DIGIT_W;
    localparam int DIFF_W       = SAMPLE_W + 1;
    localparam int T_W          = DIFF_W + DIGIT_W + 2;
    localparam int H_W          = T_W - DIGIT_W;
    localparam int K_W          = STEP_W - FRAC_W + 1;
    localparam int SKIP_W       = 8;
    localparam int LANES        = 2;
    localparam int DATA_W       = 64;
    localparam int ADDR_W       = 4;
    localparam int TDATA_W      = 2 * SAMPLE_W;

    localparam int MAX_CHANNELS        = 2;
    localparam int MAX_OUTPUTS_DEFAULT = 64;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'h1_0000_0000);
    localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);
    localparam logic [CHAN_W-1:0] CHAN_MONO  = CHAN_W'(1);

    // register index as decoded from paddr bit 3
    localparam logic REG_STEP = 1'b0;
    localparam logic REG_CHAN = 1'b1;

    // floor result plus sticky low bits gives truncation toward zero
    function automatic logic [SAMPLE_W-1:0] trunc_zero(input logic signed [H_W-1:0] s,
                                                       input logic sticky);
        logic corr;
        corr = s[H_W-1] & sticky;
        return s[SAMPLE_W-1:0] + SAMPLE_W'(corr);
    endfunction

endpackage

[sv/linear_interp_resampler.sv]
// top level of the linear interpolation resampler, digit-serial datapath
// depends on lir_pkg
//
// Streaming linear-interpolation sample rate converter for one or two
// 16-bit channels. Frames arrive on the slave stream, interpolated frames
// leave on the master stream with tlast on the final result caused by an
// input frame. The step register holds input rate over output rate as
// unsigned 8.32 fixed point; channel_count 1 selects mono, any other value
// stereo. The first frame after reset, and frames absorbed after a phase
// advance of more than one, are taken with no result. Every other frame
// gives one or more results: each result runs through the 4-bit-digit
// serial multiplier (one digit of the 32-bit phase fraction per cycle,
// with the phase add running on the same digits) and is then moved into
// the output register once it is free or the sink is ready. The input is
// ready again as soon as the final result sits in the output register.
// Registers sit at byte address 0 (step, 40 bits) and 8 (channel_count)
// and should only be written while no frame is in progress.
module linear_interp_resampler #(
    parameter int MAX_OUTPUTS_PER_INPUT = lir_pkg::MAX_OUTPUTS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] sample_left, [31:16] sample_right
    input  logic [lir_pkg::TDATA_W-1:0]  s_axis_tdata,
    // master stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] out_left, [31:16] out_right
    output logic [lir_pkg::TDATA_W-1:0]  m_axis_tdata,
    // last_of_run
    output logic                         m_axis_tlast,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lir_pkg::ADDR_W-1:0]   paddr,
    input  logic [lir_pkg::DATA_W-1:0]   pwdata,
    output logic [lir_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lir_pkg::*;

    localparam int CNT_W = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
    localparam int DIG_W = $clog2(N_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT
    } t_state;

    // configuration
    logic [STEP_W-1:0]                r_step;
    logic [CHAN_W-1:0]                r_chan;

    // block state
    t_state                           r_state;
    logic signed [SAMPLE_W-1:0]       r_base [LANES];
    logic [FRAC_W-1:0]                r_frac;       // doubles as the digit shift register
    logic [SKIP_W-1:0]                r_skip;
    logic                             r_loaded;

    // per-frame working registers
    logic signed [SAMPLE_W-1:0]       r_b      [LANES];
    logic signed [DIFF_W-1:0]         r_d      [LANES];
    logic signed [H_W-1:0]            r_h      [LANES];
    logic                             r_sticky [LANES];
    logic                             r_stereo;
    logic [FRAC_W-1:0]                r_step_sh;
    logic                             r_carry;
    logic [DIG_W-1:0]                 r_dig;
    logic [CNT_W-1:0]                 r_cnt;

    // output register
    logic                             r_out_valid;
    logic [SAMPLE_W-1:0]              r_out [LANES];
    logic                             r_out_last;

    // combinational helpers
    logic                             cfg_wr;
    logic                             in_acc;
    logic                             stereo_now;
    logic signed [SAMPLE_W-1:0]       in_samp [LANES];
    logic [DIGIT_W-1:0]               digit;
    logic [DIGIT_W:0]                 dsum;
    logic signed [T_W-1:0]            prod [LANES];
    logic signed [T_W-1:0]            t    [LANES];
    logic signed [H_W-1:0]            s    [LANES];
    logic [SAMPLE_W-1:0]              q    [LANES];
    logic [K_W-1:0]                   k;
    logic                             run_end;
    logic                             out_free;

    // configuration port: write decode on bit 3, low bits are byte offset
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[3])
            REG_STEP: prdata = DATA_W'(r_step);
            REG_CHAN: prdata = DATA_W'(r_chan);
            default:  prdata = '0;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign stereo_now    = (MAX_CHANNELS >= 2) && (r_chan != CHAN_MONO);

    always_comb begin
        in_samp[0] = s_axis_tdata[SAMPLE_W-1:0];
        in_samp[1] = stereo_now ? s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] : '0;

        // one digit of the old fraction per cycle, shared by multiply and phase add
        digit = r_frac[DIGIT_W-1:0];
        dsum  = {1'b0, digit} + {1'b0, r_step_sh[DIGIT_W-1:0]} + (DIGIT_W+1)'(r_carry);

        for (int l = 0; l < LANES; l++) begin
            prod[l] = T_W'(r_d[l]) * T_W'($signed({1'b0, digit}));
            t[l]    = T_W'(r_h[l]) + prod[l];
            s[l]    = H_W'(r_base[l]) + r_h[l];
            q[l]    = trunc_zero(s[l], r_sticky[l]);
        end

        // integer phase advance, top step bits plus the carry out of the fraction
        k        = {1'b0, r_step[STEP_W-1:FRAC_W]} + K_W'(r_carry);
        run_end  = (k != '0) || (r_cnt == CNT_W'(MAX_OUTPUTS_PER_INPUT - 1));
        out_free = !r_out_valid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_chan      <= CHAN_RESET;
            r_state     <= ST_IDLE;
            r_frac      <= '0;
            r_skip      <= '0;
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LANES; l++) begin
                r_base[l] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3])
                    REG_STEP: r_step <= pwdata[STEP_W-1:0];
                    REG_CHAN: r_chan <= pwdata[CHAN_W-1:0];
                    default:  ;
                endcase
            end

            // cleared on a completed transaction unless a new result is loaded
            if (m_axis_tvalid && m_axis_tready && !(r_state == ST_WAIT && out_free)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (!r_loaded || r_skip != '0) begin
                            // first frame or absorbed frame: only the base moves
                            for (int l = 0; l < LANES; l++) begin
                                r_base[l] <= in_samp[l];
                            end
                            if (!r_loaded) begin
                                r_loaded <= 1'b1;
                            end else begin
                                r_skip <= r_skip - SKIP_W'(1);
                            end
                        end else begin
                            for (int l = 0; l < LANES; l++) begin
                                r_b[l]      <= in_samp[l];
                                r_d[l]      <= DIFF_W'(in_samp[l]) - DIFF_W'(r_base[l]);
                                r_h[l]      <= '0;
                                r_sticky[l] <= 1'b0;
                            end
                            r_stereo  <= stereo_now;
                            r_step_sh <= r_step[FRAC_W-1:0];
                            r_carry   <= 1'b0;
                            r_dig     <= '0;
                            r_cnt     <= '0;
                            r_state   <= ST_MUL;
                        end
                    end
                end

                ST_MUL: begin
                    for (int l = 0; l < LANES; l++) begin
                        r_h[l]      <= H_W'(t[l] >>> DIGIT_W);
                        r_sticky[l] <= r_sticky[l] | (t[l][DIGIT_W-1:0] != '0);
                    end
                    r_frac    <= {dsum[DIGIT_W-1:0], r_frac[FRAC_W-1:DIGIT_W]};
                    r_step_sh <= r_step_sh >> DIGIT_W;
                    r_carry   <= dsum[DIGIT_W];
                    r_dig     <= r_dig + DIG_W'(1);
                    if (r_dig == DIG_W'(N_DIGITS - 1)) begin
                        r_state <= ST_WAIT;
                    end
                end

                ST_WAIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out[0]    <= q[0];
                        r_out[1]    <= r_stereo ? q[1] : '0;
                        r_out_last  <= run_end;
                        if (run_end) begin
                            // cap without an advance leaves nothing to absorb
                            r_skip <= (k != '0) ? SKIP_W'(k - K_W'(1)) : '0;
                            for (int l = 0; l < LANES; l++) begin
                                r_base[l] <= r_b[l];
                            end
                            r_state <= ST_IDLE;
                        end else begin
                            for (int l = 0; l < LANES; l++) begin
                                r_h[l]      <= '0;
                                r_sticky[l] <= 1'b0;
                            end
                            r_step_sh <= r_step[FRAC_W-1:0];
                            r_carry   <= 1'b0;
                            r_dig     <= '0;
                            r_cnt     <= r_cnt + CNT_W'(1);
                            r_state   <= ST_MUL;
                        end
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out[1], r_out[0]};
    assign m_axis_tlast  = r_out_last;

endmodule

[sv/lir_checker.sv]
// port-level assertions for the linear interpolation resampler, with bind
// depends on lir_pkg and linear_interp_resampler_defines.svh
`include "linear_interp_resampler_defines.svh"

module lir_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [lir_pkg::TDATA_W-1:0]  s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lir_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic                         m_axis_tlast
);

    // a stalled result keeps its payload
    `LIR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "lir: stalled result changed")

    // a result needs the serial multiply, never the cycle after the frame
    `LIR_ASSERT_NXT(a_no_early_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "lir: result too early")

    // no new frame while the current one still owes results
    `LIR_ASSERT_IMP(a_run_blocks_input, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "lir: input taken mid-run")

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);
